@@ src/sbu_pkg.sv @@
// Shared constants and types for the slot-bits to byte unpacker.
package sbu_pkg;

  // Default upper bound on the payload length in bytes.
  localparam int unsigned MAX_PAYLOAD_BYTES_DEF = 4096;

  // Slot word that is read as zero.
  localparam logic [63:0] SENTINEL_SLOT = 64'd8888;

  // Configuration register widths and reset values.
  localparam int unsigned BPS_W = 6;
  localparam int unsigned PB_W  = 13;
  localparam logic [BPS_W-1:0] BPS_RESET = 6'd17;
  localparam logic [PB_W-1:0]  PB_RESET  = 13'd256;

  // Configuration register indexes.
  localparam logic [0:0] REG_SLOT_WIDTH    = 1'b0;
  localparam logic [0:0] REG_PAYLOAD_BYTES = 1'b1;

  // Field widths.
  localparam int unsigned SLOT_W  = 64;
  localparam int unsigned INDEX_W = 12;

  // A group of up to eight finished bytes produced by one slot.
  typedef struct packed {
    logic [SLOT_W-1:0]  data;   // byte j sits in bits [8j+7:8j]
    logic [3:0]         cnt;    // number of valid bytes, 0 to 8
    logic [INDEX_W-1:0] base;   // payload index of the first byte
    logic               done;   // the final byte of the group ends the payload
  } burst_t;

endpackage

@@ src/slot_bits_to_byte_unpacker_core.sv @@
// Top level of the slot-bits to byte unpacker: configuration, input register, units.
// Path: a slot is accepted into the input register, moves on into the burst buffer,
// and its bytes then leave through the output register. Throughput: one byte per
// cycle out of the burst buffer while out_stall is low; a slot yields up to eight
// bytes, and the single output byte lane limits the rate.
// Reset: synchronous; clears the assembly state and all valid flags, and sets
// the slot width to 17 and payload_bytes to 256.
module slot_bits_to_byte_unpacker_core #(
  parameter int unsigned MAX_PAYLOAD_BYTES = sbu_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_index,
  input  logic [sbu_pkg::PB_W-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sbu_pkg::SLOT_W-1:0]  slot_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  byte_value,
  output logic [sbu_pkg::INDEX_W-1:0] byte_index,
  output logic                        payload_done,
  output logic                        last
);
  import sbu_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);

  // Configuration registers.
  logic [BPS_W-1:0] slot_width;
  logic [PB_W-1:0]  payload_bytes;
  logic             clear;

  // Input register.
  logic              in_full;
  logic [SLOT_W-1:0] slot_r;

  logic             burst_free;
  logic             advance;
  logic [CNT_W-1:0] eff_payload;
  burst_t           burst;

  // Configuration writes; a new payload length restarts assembly.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_width    <= BPS_RESET;
      payload_bytes <= PB_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SLOT_WIDTH:    slot_width    <= cfg_data[BPS_W-1:0];
        REG_PAYLOAD_BYTES: payload_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  assign clear = cfg_write && (cfg_index == REG_PAYLOAD_BYTES);

  // Payload length clamped to the supported range.
  always_comb begin
    if (payload_bytes == '0) begin
      eff_payload = CNT_W'(1);
    end else if (32'(payload_bytes) > 32'(MAX_PAYLOAD_BYTES)) begin
      eff_payload = CNT_W'(MAX_PAYLOAD_BYTES);
    end else begin
      eff_payload = CNT_W'(payload_bytes);
    end
  end

  // Input register handshake.
  assign advance  = in_full && burst_free;
  assign in_stall = in_full && !burst_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      slot_r <= slot_word;
    end
  end

  sbu_assemble #(
    .CNT_W(CNT_W)
  ) u_assemble (
    .clk          (clk),
    .rst          (rst),
    .clear        (clear),
    .advance      (advance),
    .slot         (slot_r),
    .slot_width   (slot_width),
    .eff_payload  (eff_payload),
    .burst        (burst)
  );

  sbu_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && (burst.cnt != 4'd0)),
    .burst_in    (burst),
    .burst_free  (burst_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_value  (byte_value),
    .byte_index  (byte_index),
    .payload_done(payload_done),
    .last        (last)
  );

  // The final byte of a payload always closes the transaction group of its slot.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_done |-> last)
    else $error("payload_done without last");

  // Bytes of one slot follow each other without a gap.
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("gap inside a burst");

  // The input side stalls only while the input register holds a slot.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full)
    else $error("stall with empty input register");

  // Nothing is presented right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("activity after reset");

endmodule

@@ src/sbu_assemble.sv @@
// Byte assembly: merges one slot into the partial byte and forms a burst of bytes.
module sbu_assemble #(
  parameter int unsigned CNT_W = 13
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      advance,
  input  logic [sbu_pkg::SLOT_W-1:0] slot,
  input  logic [sbu_pkg::BPS_W-1:0]  slot_width,
  input  logic [CNT_W-1:0]          eff_payload,
  output sbu_pkg::burst_t           burst
);
  import sbu_pkg::*;

  // Assembly state.
  logic [7:0]       partial_byte;
  logic [2:0]       partial_bit_count;
  logic [CNT_W-1:0] bytes_done;

  logic             stale;
  logic [7:0]       pb_cur;
  logic [2:0]       pbc_cur;
  logic [CNT_W-1:0] bd_cur;
  logic [CNT_W-1:0] bytes_left;
  logic             near_end;
  logic [31:0]      rem_bits;
  logic [BPS_W-1:0] take;
  logic [SLOT_W-1:0] slot_z;
  logic [SLOT_W-1:0] slot_m;
  logic [70:0]      combined;
  logic [6:0]       total;
  logic [3:0]       nbytes;
  logic             done;
  logic [31:0]      bd_sum;

  // A payload that already ended restarts before the slot is merged.
  always_comb begin
    stale   = 32'(bytes_done) >= 32'(eff_payload);
    pb_cur  = stale ? 8'd0 : partial_byte;
    pbc_cur = stale ? 3'd0 : partial_bit_count;
    bd_cur  = stale ? '0 : bytes_done;
  end

  // Bits taken from the slot are limited by what the payload still misses.
  always_comb begin
    bytes_left = eff_payload - bd_cur;
    near_end   = 32'(bytes_left) < 32'd9;
    rem_bits   = (32'(bytes_left) << 3) - 32'(pbc_cur);
    if (near_end && (rem_bits < 32'(slot_width))) begin
      take = BPS_W'(rem_bits);
    end else begin
      take = slot_width;
    end
  end

  // Append the taken slot bits above the bits already held.
  always_comb begin
    slot_z   = (slot == SENTINEL_SLOT) ? '0 : slot;
    slot_m   = slot_z & ~({SLOT_W{1'b1}} << take);
    combined = ({7'd0, slot_m} << pbc_cur) | 71'(pb_cur);
    total    = 7'(pbc_cur) + 7'(take);
    nbytes   = total[6:3];
    bd_sum   = 32'(bd_cur) + 32'(nbytes);
    done     = (nbytes != 4'd0) && (bd_sum == 32'(eff_payload));
  end

  // Burst handed to the emitter.
  always_comb begin
    burst.data = combined[SLOT_W-1:0];
    burst.cnt  = nbytes;
    burst.base = INDEX_W'(32'(bd_cur));
    burst.done = done;
  end

  // State update when a slot is consumed.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      partial_byte      <= '0;
      partial_bit_count <= '0;
      bytes_done        <= '0;
    end else if (advance) begin
      if (done) begin
        partial_byte      <= '0;
        partial_bit_count <= '0;
        bytes_done        <= '0;
      end else begin
        partial_byte      <= 8'(combined >> {nbytes, 3'b000});
        partial_bit_count <= total[2:0];
        bytes_done        <= CNT_W'(bd_sum);
      end
    end
  end

endmodule

@@ src/sbu_emit.sv @@
// Burst buffer and output register: sends the bytes of one burst one per cycle while the output is not stalled.
module sbu_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  sbu_pkg::burst_t             burst_in,
  output logic                        burst_free,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  byte_value,
  output logic [sbu_pkg::INDEX_W-1:0] byte_index,
  output logic                        payload_done,
  output logic                        last
);
  import sbu_pkg::*;

  // Held burst and read pointer.
  burst_t     burst;
  logic       burst_valid;
  logic [2:0] burst_ptr;

  logic out_load;
  logic at_end;

  always_comb begin
    at_end     = {1'b0, burst_ptr} == (burst.cnt - 4'd1);
    out_load   = burst_valid && (!out_valid || !out_stall);
    burst_free = !burst_valid || (out_load && at_end);
  end

  // Burst buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      burst_ptr   <= '0;
    end else if (load) begin
      burst_valid <= 1'b1;
      burst_ptr   <= '0;
    end else if (out_load) begin
      if (at_end) begin
        burst_valid <= 1'b0;
      end
      burst_ptr <= burst_ptr + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst <= burst_in;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      byte_value   <= burst.data[{burst_ptr, 3'b000} +: 8];
      byte_index   <= burst.base + INDEX_W'(burst_ptr);
      payload_done <= burst.done && at_end;
      last         <= at_end;
    end
  end

endmodule
